### hdl/dbff_pkg.sv
package dbff_pkg;

    // Default sizes of the back store and the dirty marks
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 160;
    localparam int DEF_MAX_BLOCKS = 160;

    // Width of effective frame dimensions (values up to 256)
    localparam int DIM_W   = 9;
    // Width of coordinates carried in a command
    localparam int COORD_W = 8;
    // Command queue depth
    localparam int QUEUE_DEPTH = 4;

    // One channel level step of the 2-bit store codes
    localparam logic [7:0] CH_STEP = 8'd85;

    // Register reset values
    localparam logic [7:0] RST_FRAME_WIDTH  = 8'd128;
    localparam logic [7:0] RST_FRAME_HEIGHT = 8'd160;
    localparam logic [2:0] RST_BLOCK_SHIFT  = 3'd3;

    // Request and result kinds
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BLOCK_SHIFT  = 2'd2
    } cfg_reg_t;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        CMD_WRITE      = 2'd0,
        CMD_PIXEL      = 2'd1,
        CMD_PIXEL_DONE = 2'd2,
        CMD_DONE       = 2'd3
    } cmd_op_t;

    typedef struct packed {
        logic        req_type;
        logic [6:0]  pix_x;
        logic [7:0]  pix_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } in_item_t;

    typedef struct packed {
        logic        out_kind;
        logic [15:0] lcd_color;
        logic [6:0]  out_x;
        logic [7:0]  out_y;
        logic        block_last;
    } out_item_t;

    typedef struct packed {
        cmd_op_t              op;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   row;
        logic [5:0]           code;
        logic                 last;
    } cmd_t;

    // Front-side view of the queue and the back
    typedef struct packed {
        logic q_full;
        logic clr_busy;
    } front_stat_t;

    // RGB565 field values of levels 0/85/170/255
    localparam logic [4:0] LVL5 [4] = '{5'd0, 5'd10, 5'd21, 5'd31};
    localparam logic [5:0] LVL6 [4] = '{6'd0, 6'd21, 6'd42, 6'd63};

    // 8-bit channel to 2-bit code (value divided by 85)
    function automatic logic [1:0] channel_code(logic [7:0] v);
        logic [1:0] c;
        if (v >= 8'(3 * CH_STEP))      c = 2'd3;
        else if (v >= 8'(2 * CH_STEP)) c = 2'd2;
        else if (v >= CH_STEP)         c = 2'd1;
        else                           c = 2'd0;
        return c;
    endfunction

    // Stored 6-bit pixel to RGB565 word
    function automatic logic [15:0] to_rgb565(logic [5:0] c);
        return {LVL5[c[5:4]], LVL6[c[3:2]], LVL5[c[1:0]]};
    endfunction

endpackage

### hdl/dbff_ram.sv
module dbff_ram import dbff_pkg::*; #(
    parameter int WIDTH = 6,
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/dbff_queue.sv
module dbff_queue import dbff_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic not_empty,
    output cmd_t head_cmd,
    input  logic pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hdl/dbff_front.sv
module dbff_front import dbff_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config writes
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_payload,
    // queue side
    input  front_stat_t stat,
    output logic        push,
    output cmd_t        push_cmd
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int BLK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic [7:0]            frame_width_reg;
    logic [7:0]            frame_height_reg;
    logic [2:0]            block_shift_reg;
    logic [COL_W-1:0]      scan_col_reg, scan_col_next;
    logic [ROW_W-1:0]      scan_row_reg, scan_row_next;
    logic [MAX_BLOCKS-1:0] marks_reg, marks_next;

    logic [DIM_W-1:0] eff_w, eff_h;
    logic             accept;
    logic             is_write;
    logic             in_frame;
    logic [7:0]       wr_blk;
    logic             wr_mark;
    logic             restart;
    logic [COL_W-1:0] cur_x;
    logic [ROW_W-1:0] cur_y;
    logic [DIM_W-1:0] x1, y1, blk_mask;
    logic [7:0]       sc_blk;
    logic             dirty, row_end, frame_end, blk_last;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            block_shift_reg  <= RST_BLOCK_SHIFT;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                CFG_BLOCK_SHIFT:  block_shift_reg  <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as 1, clamp to the store size
    always_comb begin
        if (frame_width_reg == '0)                      eff_w = DIM_W'(1);
        else if (DIM_W'(frame_width_reg) > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
        else                                            eff_w = DIM_W'(frame_width_reg);
        if (frame_height_reg == '0)                     eff_h = DIM_W'(1);
        else if (DIM_W'(frame_height_reg) > DIM_W'(MAX_HEIGHT)) eff_h = DIM_W'(MAX_HEIGHT);
        else                                            eff_h = DIM_W'(frame_height_reg);
    end

    assign s_ready  = !stat.q_full && !stat.clr_busy;
    assign accept   = s_valid && s_ready;
    assign is_write = (s_payload.req_type == REQ_WRITE);

    // Write classification
    assign in_frame = (DIM_W'(s_payload.pix_x) < eff_w) && (DIM_W'(s_payload.pix_y) < eff_h);
    assign wr_blk   = s_payload.pix_y >> block_shift_reg;
    assign wr_mark  = in_frame && (DIM_W'(wr_blk) < DIM_W'(MAX_BLOCKS));

    // Flush classification at the current scan position
    assign restart  = (DIM_W'(scan_col_reg) >= eff_w) || (DIM_W'(scan_row_reg) >= eff_h);
    assign cur_x    = restart ? '0 : scan_col_reg;
    assign cur_y    = restart ? '0 : scan_row_reg;
    assign x1       = DIM_W'(cur_x) + DIM_W'(1);
    assign y1       = DIM_W'(cur_y) + DIM_W'(1);
    assign sc_blk   = 8'(cur_y) >> block_shift_reg;
    assign dirty    = (DIM_W'(sc_blk) < DIM_W'(MAX_BLOCKS)) && marks_reg[sc_blk[BLK_W-1:0]];
    assign row_end  = (x1 == eff_w);
    assign frame_end = row_end && (y1 == eff_h);
    assign blk_mask = (DIM_W'(1) << block_shift_reg) - DIM_W'(1);
    assign blk_last = row_end && (((y1 & blk_mask) == '0) || (y1 == eff_h));

    // Command toward the back
    always_comb begin
        push_cmd = '0;
        push     = 1'b0;
        if (is_write) begin
            push_cmd.op   = CMD_WRITE;
            push_cmd.col  = COORD_W'(s_payload.pix_x);
            push_cmd.row  = COORD_W'(s_payload.pix_y);
            push_cmd.code = {channel_code(s_payload.red),
                             channel_code(s_payload.green),
                             channel_code(s_payload.blue)};
            push          = accept && in_frame;
        end else begin
            if (dirty && frame_end) push_cmd.op = CMD_PIXEL_DONE;
            else if (dirty)         push_cmd.op = CMD_PIXEL;
            else                    push_cmd.op = CMD_DONE;
            push_cmd.col  = COORD_W'(cur_x);
            push_cmd.row  = COORD_W'(cur_y);
            push_cmd.last = blk_last;
            push          = accept && (dirty || frame_end);
        end
    end

    // Scan position and dirty marks
    always_comb begin
        scan_col_next = scan_col_reg;
        scan_row_next = scan_row_reg;
        marks_next    = marks_reg;
        if (accept && is_write) begin
            if (wr_mark) begin
                marks_next[wr_blk[BLK_W-1:0]] = 1'b1;
            end
        end else if (accept) begin
            if (frame_end) begin
                scan_col_next = '0;
                scan_row_next = '0;
                marks_next    = '0;
            end else if (row_end) begin
                scan_col_next = '0;
                scan_row_next = ROW_W'(y1);
            end else begin
                scan_col_next = COL_W'(x1);
                scan_row_next = cur_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_col_reg <= '0;
            scan_row_reg <= '0;
            marks_reg    <= '0;
        end else begin
            scan_col_reg <= scan_col_next;
            scan_row_reg <= scan_row_next;
            marks_reg    <= marks_next;
        end
    end

endmodule

### hdl/dbff_back.sv
module dbff_back import dbff_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic      aclk,
    input  logic      aresetn,
    // queue side
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      clr_busy,
    // result items
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;
    logic              done_pend_reg;

    logic              is_wr;
    logic              out_free;
    logic              s1_adv;
    logic [ADDR_W-1:0] addr;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [5:0]        ram_wdata, ram_rdata;
    out_item_t         done_item;
    out_item_t         pix_item;

    // Queue pop: writes go straight to the store, reads wait for stage 1
    assign is_wr    = (q_cmd.op == CMD_WRITE);
    assign out_free = !out_valid_reg || (m_ready && !done_pend_reg);
    assign s1_adv   = s1_valid_reg && out_free;
    assign q_pop    = q_valid && !clr_busy_reg && (is_wr || !s1_valid_reg || s1_adv);
    assign addr     = ADDR_W'(32'(q_cmd.row) * MAX_WIDTH + 32'(q_cmd.col));

    // Store port: clearing pass after reset, then item writes
    assign ram_we    = clr_busy_reg || (q_pop && is_wr);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : addr;
    assign ram_wdata = clr_busy_reg ? '0 : q_cmd.code;
    assign ram_re    = q_pop && ((q_cmd.op == CMD_PIXEL) || (q_cmd.op == CMD_PIXEL_DONE));

    dbff_ram #(
        .WIDTH (6),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign clr_busy = clr_busy_reg;

    // Stage 1: command whose store data arrives this cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (q_pop && !is_wr) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && !is_wr) begin
            s1_cmd_reg <= q_cmd;
        end
    end

    // Result items
    always_comb begin
        done_item          = '0;
        done_item.out_kind = KIND_DONE;
        pix_item            = '0;
        pix_item.out_kind   = KIND_PIXEL;
        pix_item.lcd_color  = to_rgb565(ram_rdata);
        pix_item.out_x      = s1_cmd_reg.col[6:0];
        pix_item.out_y      = s1_cmd_reg.row[7:0];
        pix_item.block_last = s1_cmd_reg.last;
    end

    // Output register; a frame-done item may follow a pixel item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            done_pend_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= 1'b1;
            done_pend_reg <= (s1_cmd_reg.op == CMD_PIXEL_DONE);
        end else if (out_valid_reg && m_ready) begin
            if (done_pend_reg) begin
                done_pend_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            out_item_reg <= (s1_cmd_reg.op == CMD_DONE) ? done_item : pix_item;
        end else if (out_valid_reg && m_ready && done_pend_reg) begin
            out_item_reg <= done_item;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_item_reg;

    // Nothing leaves the queue while the store is being cleared
    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !q_pop)
        else $error("queue popped during clearing pass");

    // A pending frame-done always sits behind a shown pixel item
    a_pend_behind_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        done_pend_reg |-> (out_valid_reg && (out_item_reg.out_kind == KIND_PIXEL)))
        else $error("pending frame-done without pixel item");

    // Stage 1 never holds a write command
    a_s1_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (s1_cmd_reg.op != CMD_WRITE))
        else $error("write command in read stage");

endmodule

### hdl/dirty_block_framebuffer_flush_unit.sv
// Channel  Ports                                   Direction  Moves
// -------  --------------------------------------  ---------  ----------------------------
// s_       s_valid, s_ready, s_payload             in         pixel write or flush step
// m_       m_valid, m_ready, m_payload             out        panel pixel or frame done
// cfg_     cfg_valid, cfg_ready, cfg_index, _wdata in         register write
//
// The front takes one item per cycle while s_ready is high and queues a command (4 deep);
// the back takes one command per cycle, a read only if stage 1 is free or advancing.
// A flush step that ends the frame on a dirty block gives a pixel, then a frame done.
// After reset the back store is cleared one entry per cycle, MAX_WIDTH*MAX_HEIGHT entries
// (20480 by default), while s_ready stays low; cfg_ready is always high.
// s_ready drops when the command queue is full; results wait in the output register.
module dirty_block_framebuffer_flush_unit import dbff_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    front_stat_t stat;
    logic        push;
    cmd_t        push_cmd;
    logic        q_full;
    logic        q_valid;
    cmd_t        q_cmd;
    logic        q_pop;
    logic        clr_busy;

    assign cfg_ready     = 1'b1;
    assign stat.q_full   = q_full;
    assign stat.clr_busy = clr_busy;

    dbff_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .stat      (stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    dbff_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .not_empty (q_valid),
        .head_cmd  (q_cmd),
        .pop       (q_pop)
    );

    dbff_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .clr_busy  (clr_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

### tb/dirty_block_framebuffer_flush_unit_tb.sv
module dirty_block_framebuffer_flush_unit_tb;
    import dbff_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    // queue depth plus back stage plus output register, with margin
    localparam int SETTLE_CYCLES  = 12;

    typedef enum int unsigned {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_LONG_STALL
    } ready_mode_e;

    // Zero acts as one, values above the store size act as the maximum
    function automatic int unsigned clamp_dim(int unsigned v, int unsigned limit);
        return (v == 0) ? 1 : ((v > limit) ? limit : v);
    endfunction

    // Tracks the back store, the dirty marks and the scan position, and
    // holds the panel items that each accepted request should produce.
    class flush_tracker;
        bit [5:0]    stored_code [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
        bit          block_dirty [DEF_MAX_BLOCKS];
        int unsigned col_pos;
        int unsigned row_pos;
        bit [7:0]    width_reg;
        bit [7:0]    height_reg;
        bit [2:0]    shift_reg;
        out_item_t   pending_pixels [$];
        int unsigned mismatches;
        int unsigned pixels_seen;
        int unsigned frames_seen;

        function new();
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            shift_reg  = RST_BLOCK_SHIFT;
        endfunction

        function int unsigned outstanding();
            return pending_pixels.size();
        endfunction

        function bit [1:0] code_of(bit [7:0] v);
            return 2'(v / 85);
        endfunction

        function void write_reg(cfg_reg_t idx, bit [7:0] val);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg  = val;
                CFG_FRAME_HEIGHT: height_reg = val;
                CFG_BLOCK_SHIFT:  shift_reg  = val[2:0];
                default: ;
            endcase
        endfunction

        function void take_request(in_item_t it);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned y;
            int unsigned blk;
            int unsigned lvl_r;
            int unsigned lvl_g;
            int unsigned lvl_b;
            bit [5:0]    code;
            bit          row_end;
            bit          frame_end;
            out_item_t   o;
            w = clamp_dim(width_reg, DEF_MAX_WIDTH);
            h = clamp_dim(height_reg, DEF_MAX_HEIGHT);

            // pixel write: store and mark, nothing emitted
            if (it.req_type == REQ_WRITE) begin
                if (it.pix_x < w && it.pix_y < h) begin
                    stored_code[it.pix_y*DEF_MAX_WIDTH + it.pix_x] =
                        {code_of(it.red), code_of(it.green), code_of(it.blue)};
                    blk = it.pix_y >> shift_reg;
                    if (blk < DEF_MAX_BLOCKS) block_dirty[blk] = 1'b1;
                end
                return;
            end

            // scan left outside the frame by a register change restarts
            if (col_pos >= w || row_pos >= h) begin
                col_pos = 0;
                row_pos = 0;
            end
            x = col_pos;
            y = row_pos;
            blk = y >> shift_reg;
            row_end = (x + 1 == w);
            frame_end = row_end && (y + 1 == h);

            if (blk < DEF_MAX_BLOCKS && block_dirty[blk]) begin
                code  = stored_code[y*DEF_MAX_WIDTH + x];
                lvl_r = 85 * code[5:4];
                lvl_g = 85 * code[3:2];
                lvl_b = 85 * code[1:0];
                o = '0;
                o.out_kind   = KIND_PIXEL;
                o.lcd_color  = {5'(lvl_r >> 3), 6'(lvl_g >> 2), 5'(lvl_b >> 3)};
                o.out_x      = 7'(x);
                o.out_y      = 8'(y);
                // last row of the frame closes a block even when it is partial
                o.block_last = row_end &&
                    ((((y + 1) & ((1 << shift_reg) - 1)) == 0) || (y + 1 == h));
                pending_pixels.push_back(o);
            end

            if (frame_end) begin
                o = '0;
                o.out_kind = KIND_DONE;
                pending_pixels.push_back(o);
                foreach (block_dirty[i]) block_dirty[i] = 1'b0;
                col_pos = 0;
                row_pos = 0;
            end else if (row_end) begin
                col_pos = 0;
                row_pos = y + 1;
            end else begin
                col_pos = x + 1;
            end
        endfunction

        function void report_field(string name, logic [15:0] want, logic [15:0] seen);
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
            mismatches++;
        endfunction

        function void check_pixel_out(out_item_t got);
            out_item_t want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected item, expected none, got %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.out_kind !== want.out_kind)
                report_field("out_kind", want.out_kind, got.out_kind);
            if (got.lcd_color !== want.lcd_color)
                report_field("lcd_color", want.lcd_color, got.lcd_color);
            if (got.out_x !== want.out_x)
                report_field("out_x", want.out_x, got.out_x);
            if (got.out_y !== want.out_y)
                report_field("out_y", want.out_y, got.out_y);
            if (got.block_last !== want.block_last)
                report_field("block_last", want.block_last, got.block_last);
            if (want.out_kind == KIND_DONE) frames_seen++;
            else pixels_seen++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_FRAME_WIDTH;
    logic [7:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_payload;

    flush_tracker tracker;
    int unsigned  burst_left;
    int unsigned  requests_sent;
    int unsigned  settings_used;
    int unsigned  quiet_cycles;
    int unsigned  stall_tick;
    ready_mode_e  stall_mode = READY_ALWAYS;

    dirty_block_framebuffer_flush_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Monitor: every handshake at the edge, sampled before the edge updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) tracker.write_reg(cfg_reg_t'(cfg_index), cfg_wdata);
            if (s_valid && s_ready) tracker.take_request(s_payload);
            if (m_valid && m_ready) tracker.check_pixel_out(m_payload);
        end
    end

    // Receiver back-pressure, switching between four patterns at random
    always @(posedge aclk) begin
        if (stall_tick % 64 == 0) stall_mode = ready_mode_e'($urandom_range(0, 3));
        case (stall_mode)
            READY_ALWAYS:     m_ready <= 1'b1;
            READY_COIN:       m_ready <= 1'($urandom_range(0, 1));
            READY_PERIODIC:   m_ready <= (stall_tick % 5 != 0);
            READY_LONG_STALL: m_ready <= (stall_tick % 16 >= 10);
            default:          m_ready <= 1'b1;
        endcase
        stall_tick++;
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Sender: bursts of random length separated by random gaps
    task automatic push_item(in_item_t it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        requests_sent++;
    endtask

    task automatic write_pixel(int unsigned x, int unsigned y,
                               bit [7:0] r, bit [7:0] g, bit [7:0] b);
        in_item_t it;
        it = '0;
        it.req_type = REQ_WRITE;
        it.pix_x    = 7'(x);
        it.pix_y    = 8'(y);
        it.red      = r;
        it.green    = g;
        it.blue     = b;
        push_item(it);
    endtask

    // Channel values lean toward the level thresholds
    function automatic bit [7:0] pick_channel();
        bit [7:0] edges [7] = '{8'd0, 8'd84, 8'd85, 8'd169, 8'd170, 8'd254, 8'd255};
        return ($urandom_range(0, 3) == 0) ? edges[$urandom_range(0, 6)] : 8'($urandom);
    endfunction

    task automatic random_write(int unsigned ew, int unsigned eh, bit anywhere);
        int unsigned x;
        int unsigned y;
        x = anywhere ? $urandom_range(0, 127) : $urandom_range(0, ew - 1);
        y = anywhere ? $urandom_range(0, 255) : $urandom_range(0, eh - 1);
        write_pixel(x, y, pick_channel(), pick_channel(), pick_channel());
    endtask

    // Flush step; the unused fields carry noise
    task automatic flush_step();
        in_item_t it;
        it.req_type = REQ_FLUSH;
        it.pix_x    = 7'($urandom);
        it.pix_y    = 8'($urandom);
        it.red      = 8'($urandom);
        it.green    = 8'($urandom);
        it.blue     = 8'($urandom);
        push_item(it);
    endtask

    // Hold the sender until every expected item is out and the block is quiet
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Back-to-back writes of all three registers
    task automatic load_frame_regs(bit [7:0] w, bit [7:0] h, bit [2:0] sh);
        cfg_reg_t idx [3] = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_BLOCK_SHIFT};
        bit [7:0] val [3];
        val = '{w, h, 8'(sh)};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // One setting: mostly writes followed by a full frame of flush steps,
    // with writes during the scan, stray writes and cut-short frames mixed in
    task automatic run_phase(bit [7:0] w, bit [7:0] h, bit [2:0] sh,
                             int unsigned budget, bit pause_midway);
        int unsigned ew;
        int unsigned eh;
        int unsigned sent;
        int unsigned flush_left;
        int unsigned k;
        bit          paused;
        drain_results();
        load_frame_regs(w, h, sh);
        ew = clamp_dim(w, DEF_MAX_WIDTH);
        eh = clamp_dim(h, DEF_MAX_HEIGHT);
        sent = 0;
        flush_left = 0;
        paused = 1'b0;
        while (sent < budget) begin
            if (pause_midway && !paused && sent >= budget / 2) begin
                drain_results();
                paused = 1'b1;
            end
            if (flush_left == 0) begin
                k = $urandom_range(0, 6);
                repeat (k) random_write(ew, eh, $urandom_range(0, 9) == 0);
                sent += k;
                flush_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, ew * eh)
                                                         : ew * eh;
            end else if ($urandom_range(0, 11) == 0) begin
                random_write(ew, eh, 1'b0);
                sent++;
            end else begin
                flush_step();
                flush_left--;
                sent++;
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // the store clears after reset; wait for the block to take items
        do @(posedge aclk); while (!s_ready);

        // Directed: corner pixels at reset sizes, then a 3x5 frame with two-row
        // blocks, a clean middle block, a partial last block and stray writes
        write_pixel(0, 0, 8'd255, 8'd255, 8'd255);
        write_pixel(127, 159, 8'd254, 8'd169, 8'd84);
        drain_results();
        load_frame_regs(8'd3, 8'd5, 3'd1);
        write_pixel(0, 0, 8'd85, 8'd170, 8'd255);
        write_pixel(2, 1, 8'd84, 8'd85, 8'd169);
        write_pixel(1, 4, 8'd170, 8'd254, 8'd0);
        write_pixel(2, 4, 8'd255, 8'd0, 8'd85);
        write_pixel(3, 0, 8'd255, 8'd255, 8'd255);
        write_pixel(0, 5, 8'd255, 8'd255, 8'd255);
        repeat (16) flush_step();

        // Extreme settings, then small random frames
        run_phase(8'd128, 8'd2, 3'd0, 330, 1'b1);
        run_phase(8'd1, 8'd160, 3'd7, 330, 1'b0);
        run_phase(8'd0, 8'd0, 3'd0, 40, 1'b0);
        run_phase(8'd255, 8'd1, 3'd2, 300, 1'b0);
        run_phase(8'd1, 8'd255, 3'd5, 200, 1'b0);
        repeat (6) begin
            run_phase(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                      3'($urandom_range(0, 7)), 60, 1'b0);
        end

        drain_results();
        $display("%0d requests over %0d register settings; %0d panel pixels and %0d frame ends checked",
                 requests_sent, settings_used, tracker.pixels_seen, tracker.frames_seen);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d items never arrived",
                     tracker.mismatches, tracker.outstanding());
            $display("status: fail");
        end
        $finish;
    end

endmodule
